// ===== src/avt_pkg.sv =====
package avt_pkg;

  // Fraction bits of the fixed-point format (Q16.16 by default)
  localparam int FRAC_BITS = 16;

  // Matrix geometry: three rows of four elements, last column is translation
  localparam int NUM_ROWS  = 3;
  localparam int ROW_ELEMS = 4;
  localparam int NUM_ELEMS = NUM_ROWS * ROW_ELEMS;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;
  localparam int PROD_W  = 2 * VALUE_W;
  // Exact sum of three full products needs two guard bits
  localparam int SUM_W   = PROD_W + 2;

  // Stream word widths
  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 96;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_NORMAL = 2'd2
  } cmd_t;

  // Result of one row lane handed to the merge stage
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               sat;
  } lane_res_t;

endpackage

// ===== src/avt_lane.sv =====
module avt_lane #(
  parameter int FRAC_BITS = avt_pkg::FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [avt_pkg::VALUE_W-1:0] vec_x,
  input  logic signed [avt_pkg::VALUE_W-1:0] vec_y,
  input  logic signed [avt_pkg::VALUE_W-1:0] vec_z,
  input  logic signed [avt_pkg::VALUE_W-1:0] coef_x,
  input  logic signed [avt_pkg::VALUE_W-1:0] coef_y,
  input  logic signed [avt_pkg::VALUE_W-1:0] coef_z,
  input  logic signed [avt_pkg::VALUE_W-1:0] trans,
  output avt_pkg::lane_res_t                 res
);

  localparam int SUM_W = avt_pkg::SUM_W;
  localparam int PW    = avt_pkg::PROD_W;
  localparam int VW    = avt_pkg::VALUE_W;

  localparam logic signed [SUM_W:0] MAX_POS = {{(SUM_W-VW+2){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SUM_W:0] MIN_NEG = {{(SUM_W-VW+2){1'b1}}, {(VW-1){1'b0}}};

  logic signed [PW-1:0]    prod_x;
  logic signed [PW-1:0]    prod_y;
  logic signed [PW-1:0]    prod_z;
  logic signed [VW-1:0]    trans1;
  logic signed [SUM_W-1:0] sum;
  logic signed [VW-1:0]    trans2;
  logic signed [SUM_W-1:0] shifted;
  logic signed [SUM_W:0]   total;

  // Multiply stage: three full-width products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= vec_x * coef_x;
      prod_y <= vec_y * coef_y;
      prod_z <= vec_z * coef_z;
      trans1 <= trans;
    end
  end

  // Sum stage: exact row sum
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= {{2{prod_x[PW-1]}}, prod_x} + {{2{prod_y[PW-1]}}, prod_y}
           + {{2{prod_z[PW-1]}}, prod_z};
      trans2 <= trans1;
    end
  end

  // Floor back to the fixed format, add translation, clip to 32 bits
  always_comb begin
    shifted = sum >>> FRAC_BITS;
    total   = {shifted[SUM_W-1], shifted} + {{(SUM_W-VW+1){trans2[VW-1]}}, trans2};
    if (total > MAX_POS) begin
      res.value = MAX_POS[VW-1:0];
      res.sat   = 1'b1;
    end else if (total < MIN_NEG) begin
      res.value = MIN_NEG[VW-1:0];
      res.sat   = 1'b1;
    end else begin
      res.value = total[VW-1:0];
      res.sat   = 1'b0;
    end
  end

endmodule

// ===== src/avt_merge.sv =====
module avt_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            valid_in,
  input  avt_pkg::lane_res_t              lane_res [avt_pkg::NUM_ROWS],
  output logic                            m_tvalid,
  output logic [avt_pkg::M_DATA_W-1:0]    m_tdata,
  output logic                            m_tuser
);

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= valid_in;
    end
  end

  // Combine the lanes into one result word, flag any clipped component
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {lane_res[2].value, lane_res[1].value, lane_res[0].value};
      m_tuser <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
    end
  end

endmodule

// ===== src/affine_vertex_transform_unit.sv =====
// Affine vertex transform unit. Holds a 3x4 signed fixed-point matrix (FRAC_BITS
// fraction bits, Q16.16 by default) that resets to identity with zero translation.
// A load word (tuser 0) writes one element, row*4+column, and gives
// no result; indices 12..15 write nothing. A point word (tuser 1) returns M*(x,y,z)
// plus the translation column, a normal word (tuser 2) the 3x3 part only; tuser 3
// is dropped. Each row is the exact sum of three 64-bit products floored at
// FRAC_BITS, then translated and clipped to 32 bits; result tuser flags any clip.
// One word is taken per cycle unless the pipeline stalls; a result is valid once its word
// has passed the multiply and sum registers of the row lanes and the output register
// of the merge stage.
// A load takes effect for the very next word. The pipeline stalls only while a
// result waits on the master side.
module affine_vertex_transform_unit #(
  parameter int FRAC_BITS = avt_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [3:0] element_index, [35:4] element_value, [67:36] vec_x,
  // [99:68] vec_y, [131:100] vec_z, [135:132] zero
  input  logic [avt_pkg::S_DATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [avt_pkg::CMD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z
  output logic [avt_pkg::M_DATA_W-1:0]  m_tdata,
  // [0] saturated
  output logic                          m_tuser
);

  localparam int VW = avt_pkg::VALUE_W;
  localparam logic [VW-1:0] ONE = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic [VW-1:0]                  matrix [avt_pkg::NUM_ELEMS];
  logic                           advance;
  logic                           s_fire;
  logic                           vec_fire;
  avt_pkg::cmd_t                  cmd;
  logic [avt_pkg::INDEX_W-1:0]    elem_index;
  logic [VW-1:0]                  elem_value;
  logic signed [VW-1:0]           vec_x;
  logic signed [VW-1:0]           vec_y;
  logic signed [VW-1:0]           vec_z;
  logic                           v1;
  logic                           v2;
  avt_pkg::lane_res_t             lane_res [avt_pkg::NUM_ROWS];

  // Unpack the input word
  assign cmd        = avt_pkg::cmd_t'(s_tuser);
  assign elem_index = s_tdata[3:0];
  assign elem_value = s_tdata[35:4];
  assign vec_x      = s_tdata[67:36];
  assign vec_y      = s_tdata[99:68];
  assign vec_z      = s_tdata[131:100];

  // Advance the whole pipeline unless a result is held on the master side
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign s_fire   = s_tvalid && s_tready;
  assign vec_fire = s_fire && (cmd == avt_pkg::CMD_POINT || cmd == avt_pkg::CMD_NORMAL);

  // Matrix registers: identity at reset, one element per load word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < avt_pkg::NUM_ROWS; r++) begin
        for (int c = 0; c < avt_pkg::ROW_ELEMS; c++) begin
          matrix[r*avt_pkg::ROW_ELEMS+c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (s_fire && cmd == avt_pkg::CMD_LOAD &&
                 elem_index < avt_pkg::INDEX_W'(avt_pkg::NUM_ELEMS)) begin
      matrix[elem_index] <= elem_value;
    end
  end

  // Valid bits of the multiply and sum stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= vec_fire;
      v2 <= v1;
    end
  end

  // One lane per matrix row
  for (genvar r = 0; r < avt_pkg::NUM_ROWS; r++) begin : g_lane
    logic signed [VW-1:0] trans;

    // Translation only for points
    assign trans = (cmd == avt_pkg::CMD_POINT) ? matrix[r*avt_pkg::ROW_ELEMS+3] : '0;

    avt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (advance),
      .vec_x  (vec_x),
      .vec_y  (vec_y),
      .vec_z  (vec_z),
      .coef_x (matrix[r*avt_pkg::ROW_ELEMS+0]),
      .coef_y (matrix[r*avt_pkg::ROW_ELEMS+1]),
      .coef_z (matrix[r*avt_pkg::ROW_ELEMS+2]),
      .trans  (trans),
      .res    (lane_res[r])
    );
  end

  avt_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .valid_in (v2),
    .lane_res (lane_res),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_fire && cmd == avt_pkg::CMD_LOAD) |=> !v1)
    else $error("load word entered the pipeline");

  a_vec_enters: assert property (@(posedge clk) disable iff (rst)
    vec_fire |=> v1)
    else $error("vector word lost at the multiply stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(v1) && $stable(v2)))
    else $error("pipeline moved during a stall");

  a_load_writes: assert property (@(posedge clk) disable iff (rst)
    (s_fire && cmd == avt_pkg::CMD_LOAD && elem_index == 4'd0) |=>
    (matrix[0] == $past(elem_value)))
    else $error("matrix element not written");

  a_reset_identity: assert property (@(posedge clk)
    rst |=> (matrix[0] == ONE && matrix[5] == ONE && matrix[10] == ONE &&
             matrix[3] == '0 && matrix[7] == '0 && matrix[11] == '0))
    else $error("matrix not identity after reset");
`endif

endmodule

// ===== test/affine_vertex_transform_unit_tb.sv =====
`timescale 1ns / 100ps

module affine_vertex_transform_unit_tb;

  // Command code outside the enum; the block drops it
  localparam logic [avt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [avt_pkg::VALUE_W-1:0] Q_ONE  = 32'sd1 <<< avt_pkg::FRAC_BITS;
  localparam logic signed [avt_pkg::VALUE_W-1:0] Q_HALF = Q_ONE >>> 1;
  localparam logic signed [avt_pkg::VALUE_W-1:0] MAX32  = 32'sh7FFF_FFFF;
  localparam logic signed [avt_pkg::VALUE_W-1:0] MIN32  = 32'sh8000_0000;

  localparam int TARGET_ITEMS = 800;

  typedef struct {
    logic signed [avt_pkg::VALUE_W-1:0] x;
    logic signed [avt_pkg::VALUE_W-1:0] y;
    logic signed [avt_pkg::VALUE_W-1:0] z;
    bit                                 sat;
  } vertex_t;

  // Tracks the matrix and the transformed vertices still owed by the block
  class vertex_scoreboard;
    logic signed [avt_pkg::VALUE_W-1:0] matrix [avt_pkg::NUM_ELEMS];
    vertex_t                            expected_vertices [$];
    int                                 mismatches;

    function new();
      mismatches = 0;
      foreach (matrix[i]) matrix[i] = '0;
      matrix[0]  = Q_ONE;
      matrix[5]  = Q_ONE;
      matrix[10] = Q_ONE;
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction

    // Exact dot product of one row, floored to the fixed format, translated if asked, then clipped
    function logic signed [avt_pkg::VALUE_W-1:0] row_result(
        int row, logic signed [avt_pkg::VALUE_W-1:0] vx,
        logic signed [avt_pkg::VALUE_W-1:0] vy,
        logic signed [avt_pkg::VALUE_W-1:0] vz,
        bit translate, inout bit clipped);
      logic signed [avt_pkg::PROD_W-1:0] px, py, pz;
      logic signed [avt_pkg::SUM_W-1:0]  total;
      px = vx * matrix[row*avt_pkg::ROW_ELEMS];
      py = vy * matrix[row*avt_pkg::ROW_ELEMS+1];
      pz = vz * matrix[row*avt_pkg::ROW_ELEMS+2];
      total = px + py + pz;
      total = total >>> avt_pkg::FRAC_BITS;
      if (translate) total = total + matrix[row*avt_pkg::ROW_ELEMS+3];
      if (total > 66'sh7FFF_FFFF) begin
        clipped = 1'b1;
        total = 66'sh7FFF_FFFF;
      end else if (total < -66'sh8000_0000) begin
        clipped = 1'b1;
        total = -66'sh8000_0000;
      end
      return total[avt_pkg::VALUE_W-1:0];
    endfunction

    function void note_word(logic [avt_pkg::CMD_W-1:0] cmd,
                            logic [avt_pkg::S_DATA_W-1:0] word);
      logic [avt_pkg::INDEX_W-1:0]        idx;
      logic signed [avt_pkg::VALUE_W-1:0] vx, vy, vz;
      vertex_t                            v;
      bit                                 clipped;
      idx = word[3:0];
      vx = word[67:36];
      vy = word[99:68];
      vz = word[131:100];
      clipped = 1'b0;
      case (cmd)
        avt_pkg::CMD_LOAD: begin
          if (idx < avt_pkg::NUM_ELEMS) matrix[idx] = word[35:4];
        end
        avt_pkg::CMD_POINT, avt_pkg::CMD_NORMAL: begin
          v.x = row_result(0, vx, vy, vz, cmd == avt_pkg::CMD_POINT, clipped);
          v.y = row_result(1, vx, vy, vz, cmd == avt_pkg::CMD_POINT, clipped);
          v.z = row_result(2, vx, vy, vz, cmd == avt_pkg::CMD_POINT, clipped);
          v.sat = clipped;
          expected_vertices.push_back(v);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [avt_pkg::M_DATA_W-1:0] word, logic flag);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected vertex x=%h y=%h z=%h sat=%b", $time,
                   word[31:0], word[63:32], word[95:64], flag);
        return;
      end
      want = expected_vertices.pop_front();
      if (word[31:0] !== want.x || word[63:32] !== want.y || word[95:64] !== want.z ||
          flag !== want.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: vertex exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                   $time, want.x, want.y, want.z, want.sat,
                   word[31:0], word[63:32], word[95:64], flag);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [avt_pkg::S_DATA_W-1:0]   s_tdata;
  logic [avt_pkg::CMD_W-1:0]      s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [avt_pkg::M_DATA_W-1:0]   m_tdata;
  logic                           m_tuser;

  vertex_scoreboard sb;
  int               items_sent;
  int               burst_left;
  int               rx_left;
  int               rx_mode;

  affine_vertex_transform_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Record every accepted word and check every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  // Stall the result side, switching between patterns now and then
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(10, 120);
    end
    rx_left--;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rx_left[1:0] != 2'd0);
    endcase
  end

  // Insert a random gap between bursts of words
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
  endtask

  task automatic send_word(logic [avt_pkg::CMD_W-1:0] cmd,
                           logic [avt_pkg::INDEX_W-1:0] idx,
                           logic [avt_pkg::VALUE_W-1:0] val,
                           logic [avt_pkg::VALUE_W-1:0] vx,
                           logic [avt_pkg::VALUE_W-1:0] vy,
                           logic [avt_pkg::VALUE_W-1:0] vz);
    pace_sender();
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, vz, vy, vx, val, idx};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Vector fields of a load are ignored, so fill them with noise
  task automatic send_load(logic [avt_pkg::INDEX_W-1:0] idx,
                           logic [avt_pkg::VALUE_W-1:0] val);
    send_word(avt_pkg::CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic send_vector(logic [avt_pkg::CMD_W-1:0] cmd,
                             logic [avt_pkg::VALUE_W-1:0] vx,
                             logic [avt_pkg::VALUE_W-1:0] vy,
                             logic [avt_pkg::VALUE_W-1:0] vz);
    send_word(cmd, avt_pkg::INDEX_W'($urandom_range(0, 15)), $urandom, vx, vy, vz);
  endtask

  // Hold the sender until every owed vertex has come back
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly within +-4.0 so transforms stay in range, sometimes extreme
  function automatic logic [avt_pkg::VALUE_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return MAX32;
      1: return MIN32;
      2: return $urandom;
      default: return int'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
    endcase
  endfunction

  // Mostly within +-256.0, sometimes full range or extreme
  function automatic logic [avt_pkg::VALUE_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return MAX32;
      1: return MIN32;
      2, 3: return $urandom;
      default: return int'($urandom_range(0, 32'h1FF_FFFF)) - 32'h100_0000;
    endcase
  endfunction

  initial begin
    bit drained_mid;
    int n;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = avt_pkg::CMD_LOAD;
    m_tready = 1'b0;
    rx_left = 0;
    rx_mode = 0;
    burst_left = 0;
    items_sent = 0;
    drained_mid = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity matrix, ordinary and extreme vectors
    send_vector(avt_pkg::CMD_POINT, Q_ONE + Q_HALF, -(2 * Q_ONE + Q_ONE / 4), 3 * Q_ONE);
    send_vector(avt_pkg::CMD_NORMAL, -Q_HALF, Q_ONE, 7);
    send_vector(avt_pkg::CMD_POINT, MIN32, MAX32, MIN32);
    send_vector(avt_pkg::CMD_NORMAL, MAX32, MIN32, -1);
    // Translation clips high on a point, is skipped on a normal
    send_load(4'd3, MAX32);
    send_vector(avt_pkg::CMD_POINT, Q_ONE, 0, 0);
    send_vector(avt_pkg::CMD_NORMAL, Q_ONE, 0, 0);
    // Translation clips low
    send_load(4'd7, MIN32);
    send_vector(avt_pkg::CMD_POINT, 0, -Q_ONE, 0);
    // Out-of-range loads and the unused command change nothing
    send_load(4'd12, MIN32);
    send_load(4'd15, MAX32);
    send_word(CMD_UNUSED, 4'd0, MIN32, MAX32, MAX32, MAX32);
    send_vector(avt_pkg::CMD_POINT, Q_ONE, Q_ONE, Q_ONE);
    // Floor toward minus infinity on a half-LSB product
    send_load(4'd0, Q_HALF);
    send_vector(avt_pkg::CMD_POINT, -1, 0, 0);
    send_vector(avt_pkg::CMD_NORMAL, 1, 0, 0);
    // Huge products overflow the 32-bit range
    send_load(4'd0, MIN32);
    send_vector(avt_pkg::CMD_NORMAL, MIN32, 0, 0);
    send_load(4'd4, MAX32);
    send_load(4'd5, MAX32);
    send_load(4'd6, MAX32);
    send_vector(avt_pkg::CMD_NORMAL, MAX32, MAX32, MAX32);
    send_vector(avt_pkg::CMD_POINT, MIN32, MIN32, MIN32);
    drain_results();

    // Random part: matrix reloads followed by vector runs, plus single words
    while (items_sent < TARGET_ITEMS) begin
      if (!drained_mid && items_sent > TARGET_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end
      case ($urandom_range(0, 9))
        0: begin
          for (int i = 0; i < avt_pkg::NUM_ELEMS; i++)
            send_load(avt_pkg::INDEX_W'(i), pick_element());
          n = $urandom_range(3, 10);
          repeat (n)
            send_vector($urandom_range(0, 1) ? avt_pkg::CMD_POINT : avt_pkg::CMD_NORMAL,
                        pick_coord(), pick_coord(), pick_coord());
        end
        1: send_load(avt_pkg::INDEX_W'(($urandom_range(0, 3) == 0) ?
                                       $urandom_range(0, 15) : $urandom_range(0, 11)),
                     pick_element());
        2, 3, 4: send_vector(avt_pkg::CMD_POINT, pick_coord(), pick_coord(), pick_coord());
        5, 6, 7: send_vector(avt_pkg::CMD_NORMAL, pick_coord(), pick_coord(), pick_coord());
        8: send_vector(avt_pkg::CMD_POINT, $urandom, $urandom, $urandom);
        default: send_word(CMD_UNUSED, avt_pkg::INDEX_W'($urandom), $urandom, $urandom,
                           $urandom, $urandom);
      endcase
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up if the block stops moving
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/avt_pkg.sv
src/avt_lane.sv
src/avt_merge.sv
src/affine_vertex_transform_unit.sv
test/affine_vertex_transform_unit_tb.sv
